FILE: sv/rcd_pkg.sv
// ---------------------------------------------------------------------------
// rcd_pkg
// shared types and constants of the radiometer channel demultiplexer
// ---------------------------------------------------------------------------
package rcd_pkg;

  localparam int unsigned SPL_W   = 13;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SWL_W   = 17;
  localparam int unsigned WORD_W  = 10;
  localparam int unsigned CHO_W   = 3;
  localparam int unsigned PIXO_W  = 12;
  localparam int unsigned SKIP_W  = 7;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // stream framing
  localparam logic [SKIP_W-1:0] HEADER_WORDS = 7'd55;
  localparam logic [SKIP_W-1:0] GAP_WORDS    = 7'd112;

  // the two shared channel slots
  localparam logic [CHO_W-1:0] SHARED_A = 3'd2;
  localparam logic [CHO_W-1:0] SHARED_B = 3'd3;

  // shared slot mode codes
  localparam logic [MODE_W-1:0] MODE_KEEP_B = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEEP_A = 2'd1;

  localparam logic [SWL_W-1:0] SWITCH_NEVER = 17'h1FFFF;

  // register reset values
  localparam logic [SPL_W-1:0]  SPL_RST  = 13'd2048;
  localparam logic [LINE_W-1:0] LCNT_RST = 16'd0;
  localparam logic [MODE_W-1:0] MODE_RST = MODE_KEEP_A;
  localparam logic [SWL_W-1:0]  SWL_RST  = SWITCH_NEVER;

  typedef enum logic [1:0] {
    REG_SAMPLES_PER_LINE = 2'd0,
    REG_LINE_COUNT       = 2'd1,
    REG_SHARED_SLOT_MODE = 2'd2,
    REG_SWITCH_LINE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SPL_W-1:0]  samples_per_line;
    logic [LINE_W-1:0] line_count;
    logic [MODE_W-1:0] shared_slot_mode;
    logic [SWL_W-1:0]  switch_line;
  } rcd_cfg_t;

  typedef struct packed {
    logic [CHO_W-1:0]  channel_index;
    logic [LINE_W-1:0] line_index;
    logic [PIXO_W-1:0] pixel_index;
    logic              image_done;
  } rcd_tag_t;

endpackage

FILE: sv/rcd_regs.sv
// ---------------------------------------------------------------------------
// rcd_regs
// configuration register file behind the apb-style port
// ---------------------------------------------------------------------------
module rcd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcd_pkg::ADDR_W-1:0] paddr,
  input  logic [rcd_pkg::DATA_W-1:0] pwdata,
  output logic [rcd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rcd_pkg::rcd_cfg_t          cfg
);
  import rcd_pkg::*;

  rcd_cfg_t cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SAMPLES_PER_LINE: cfg_nxt.samples_per_line = pwdata[SPL_W-1:0];
        REG_LINE_COUNT:       cfg_nxt.line_count       = pwdata[LINE_W-1:0];
        REG_SHARED_SLOT_MODE: cfg_nxt.shared_slot_mode = pwdata[MODE_W-1:0];
        REG_SWITCH_LINE:      cfg_nxt.switch_line      = pwdata[SWL_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SAMPLES_PER_LINE: prdata = DATA_W'(cfg_r.samples_per_line);
      REG_LINE_COUNT:       prdata = DATA_W'(cfg_r.line_count);
      REG_SHARED_SLOT_MODE: prdata = DATA_W'(cfg_r.shared_slot_mode);
      REG_SWITCH_LINE:      prdata = DATA_W'(cfg_r.switch_line);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_line <= SPL_RST;
      cfg_r.line_count       <= LCNT_RST;
      cfg_r.shared_slot_mode <= MODE_RST;
      cfg_r.switch_line      <= SWL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/rcd_core.sv
// ---------------------------------------------------------------------------
// rcd_core
// stream position counters and slot selection, one word per step
// ---------------------------------------------------------------------------
module rcd_core #(
  parameter int unsigned NUM_CHANNELS = 6,
  parameter int unsigned MAX_SAMPLES  = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rcd_pkg::rcd_cfg_t cfg,
  output logic              emit,
  output rcd_pkg::rcd_tag_t tag
);
  import rcd_pkg::*;

  localparam int unsigned CH_W  = $clog2(NUM_CHANNELS);
  localparam int unsigned PIX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned WID_W = SPL_W + 1;
  localparam logic [WID_W-1:0] MAX_WID = WID_W'(MAX_SAMPLES);

  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [CH_W-1:0]   slot_r, slot_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              fin_r, fin_nxt;

  logic              skipping, flipped, found, nxt_found, line_end, last_line;
  logic [CH_W-1:0]   ci, nxt;
  logic [WID_W-1:0]  width;

  function automatic logic slot_kept(input logic [CH_W-1:0] c,
                                     input logic [MODE_W-1:0] mode,
                                     input logic flip);
    logic is_a, is_b;
    is_a = (CHO_W'(c) == SHARED_A);
    is_b = (CHO_W'(c) == SHARED_B);
    if (!is_a && !is_b) return 1'b1;
    if (mode != MODE_KEEP_A && mode != MODE_KEEP_B) return 1'b1;
    if ((mode == MODE_KEEP_A) != flip) return is_a;
    return is_b;
  endfunction

  // shared slot choice flips from the switch line onward; a negative switch line flips every line, the never code none
  always_comb begin
    if (cfg.switch_line == SWITCH_NEVER) flipped = 1'b0;
    else if (cfg.switch_line[SWL_W-1])   flipped = 1'b1;
    else flipped = (line_r >= cfg.switch_line[LINE_W-1:0]);
  end

  always_comb begin
    if (cfg.samples_per_line == '0)               width = WID_W'(1);
    else if ({1'b0, cfg.samples_per_line} > MAX_WID) width = MAX_WID;
    else                                            width = {1'b0, cfg.samples_per_line};
  end

  // first kept slot from the slot counter, wrapping to slot 0
  always_comb begin
    ci    = '0;
    found = 1'b0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (CH_W'(c) >= slot_r && slot_kept(CH_W'(c), cfg.shared_slot_mode, flipped)) begin
        ci    = CH_W'(c);
        found = 1'b1;
      end
    end
    if (!found) ci = '0;
  end

  // next kept slot after this one in the same pixel
  always_comb begin
    nxt       = '0;
    nxt_found = 1'b0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (CH_W'(c) > ci && slot_kept(CH_W'(c), cfg.shared_slot_mode, flipped)) begin
        nxt       = CH_W'(c);
        nxt_found = 1'b1;
      end
    end
  end

  assign skipping  = (skip_r != '0);
  assign emit      = !skipping && !fin_r && (line_r < cfg.line_count);
  assign line_end  = !nxt_found && ((WID_W'(pix_r) + WID_W'(1)) >= width);
  assign last_line = ({1'b0, line_r} + 17'd1) >= {1'b0, cfg.line_count};

  assign tag.channel_index = CHO_W'(ci);
  assign tag.line_index    = line_r;
  assign tag.pixel_index   = PIXO_W'(pix_r);
  assign tag.image_done    = line_end && last_line;

  always_comb begin
    skip_nxt = skip_r;
    slot_nxt = slot_r;
    pix_nxt  = pix_r;
    line_nxt = line_r;
    fin_nxt  = fin_r;
    if (step) begin
      if (skipping) begin
        skip_nxt = skip_r - SKIP_W'(1);
      end else if (emit) begin
        if (nxt_found) begin
          slot_nxt = nxt;
        end else begin
          slot_nxt = '0;
          if (line_end) begin
            pix_nxt  = '0;
            skip_nxt = GAP_WORDS;
            line_nxt = line_r + LINE_W'(1);
            if (last_line) fin_nxt = 1'b1;
          end else begin
            pix_nxt = pix_r + PIX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= HEADER_WORDS;
      slot_r <= '0;
      pix_r  <= '0;
      line_r <= '0;
      fin_r  <= 1'b0;
    end else begin
      skip_r <= skip_nxt;
      slot_r <= slot_nxt;
      pix_r  <= pix_nxt;
      line_r <= line_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

FILE: sv/radiometer_channel_demux.sv
// ---------------------------------------------------------------------------
// radiometer_channel_demux
// de-interleaves unpacked 10-bit scanner words into tagged channel samples
// ---------------------------------------------------------------------------
// path: a kept word is offered on the result port from the result register,
//   after passing through the input register
// throughput: one word per cycle while results are taken, set by the
//   counter update in rcd_core; dropped words never wait on results
// reset: synchronous active-low rst_n; registers return to their reset
//   values, the 55-word header skip is reloaded, all counters clear
module radiometer_channel_demux #(
  parameter int unsigned NUM_CHANNELS = 6,
  parameter int unsigned MAX_SAMPLES  = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // word requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rcd_pkg::WORD_W-1:0]  in_sample_word,
  // result requests
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rcd_pkg::CHO_W-1:0]   out_channel_index,
  output logic [rcd_pkg::LINE_W-1:0]  out_line_index,
  output logic [rcd_pkg::PIXO_W-1:0]  out_pixel_index,
  output logic [rcd_pkg::WORD_W-1:0]  out_sample_value,
  output logic                        out_image_done,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [rcd_pkg::DATA_W-1:0]  pwdata,
  output logic [rcd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rcd_pkg::*;

  rcd_cfg_t cfg;
  rcd_tag_t tag;
  logic     emit;
  logic     advance;

  // input register
  logic              in_vld_r, in_vld_nxt;
  logic [WORD_W-1:0] in_word_r;

  // result register
  logic              out_vld_r, out_vld_nxt;
  rcd_tag_t          out_tag_r;
  logic [WORD_W-1:0] out_word_r;

  rcd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the core works on the word held in the input register
  rcd_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cfg   (cfg),
    .emit  (emit),
    .tag   (tag)
  );

  // a held word moves on when it is dropped, or when the result register
  // is empty or being drained this cycle
  assign advance  = in_vld_r && (!emit || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) in_vld_nxt = 1'b1;
    else if (advance)         in_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && emit) out_vld_nxt = 1'b1;
    else if (out_ready)  out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_word_r <= in_sample_word;
    if (advance && emit) begin
      out_tag_r  <= tag;
      out_word_r <= in_word_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_channel_index = out_tag_r.channel_index;
  assign out_line_index    = out_tag_r.line_index;
  assign out_pixel_index   = out_tag_r.pixel_index;
  assign out_sample_value  = out_word_r;
  assign out_image_done    = out_tag_r.image_done;

endmodule

FILE: sv/rcd_checker.sv
// ---------------------------------------------------------------------------
// rcd_checker
// port-level checks on the result channel of the demultiplexer
// ---------------------------------------------------------------------------
module rcd_checker #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rcd_pkg::CHO_W-1:0]  out_channel_index,
  input logic                       out_image_done
);
  import rcd_pkg::*;

  // nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // channel tags stay within the configured channels
  a_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_channel_index) < NUM_CHANNELS))
    else $error("channel index out of range");

  // nothing follows the last sample of the image
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_image_done |=> !out_valid)
    else $error("result after image done");

endmodule

bind radiometer_channel_demux rcd_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_rcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_channel_index (out_channel_index),
  .out_image_done    (out_image_done)
);

FILE: bench/tb_radiometer_channel_demux.sv
// ---------------------------------------------------------------------------
// tb_radiometer_channel_demux
// self-checking bench for the scanner word de-interleaver: random word
// requests go in under a series of register settings written over the
// register port, a tracker predicts the tagged samples that each word
// yields, and every sample taken from the result port is checked against
// the oldest prediction, field by field
// ---------------------------------------------------------------------------
module tb_radiometer_channel_demux;
  timeunit 1ns;
  timeprecision 1ps;

  import rcd_pkg::*;

  localparam int unsigned NCH  = 6;
  localparam int unsigned MAXS = 4096;

  // mode codes without a name in the package
  localparam logic [MODE_W-1:0] MODE_KEEP_BOTH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH_ALT  = 2'd3;

  // "never switch" as software writes it, sign extended to the bus
  localparam logic [DATA_W-1:0] SWITCH_NEVER_WORD = {{(DATA_W-SWL_W){1'b1}}, SWITCH_NEVER};

  localparam int unsigned DRAIN_CYCLES = 8;      // well past the input and result registers
  localparam int unsigned HOLD_CYCLES  = 300;    // long result hold-off
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_WORDS = 820;    // word requests before the last phase

  typedef struct packed {
    logic [CHO_W-1:0]  chan;
    logic [LINE_W-1:0] row;
    logic [PIXO_W-1:0] pixel;
    logic [WORD_W-1:0] word;
    logic              done;
  } demux_sample_t;

  // tracks the framing state of the stream and the samples still owed
  class sample_tracker;
    logic [SPL_W-1:0]  spl;
    logic [LINE_W-1:0] lcnt;
    logic [MODE_W-1:0] mode;
    logic [SWL_W-1:0]  swl;
    logic [SKIP_W-1:0] skip_left;
    logic [CHO_W-1:0]  slot;
    logic [PIXO_W-1:0] pixel;
    logic [LINE_W-1:0] row;
    bit                finished;
    demux_sample_t     pending_samples[$];
    int unsigned       n_words;
    int unsigned       mismatches;

    function new();
      spl       = SPL_RST;
      lcnt      = LCNT_RST;
      mode      = MODE_RST;
      swl       = SWL_RST;
      skip_left = HEADER_WORDS;
      slot      = '0;
      pixel     = '0;
      row       = '0;
      finished  = 1'b0;
      n_words    = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_SAMPLES_PER_LINE: spl  = value[SPL_W-1:0];
        REG_LINE_COUNT:       lcnt = value[LINE_W-1:0];
        REG_SHARED_SLOT_MODE: mode = value[MODE_W-1:0];
        REG_SWITCH_LINE:      swl  = value[SWL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit slot_kept(int unsigned ci, logic [LINE_W-1:0] at_row);
      bit flipped;
      if (ci != SHARED_A && ci != SHARED_B) return 1'b1;
      if (mode != MODE_KEEP_A && mode != MODE_KEEP_B) return 1'b1;
      if (swl == SWITCH_NEVER) flipped = 1'b0;
      else if (swl[SWL_W-1]) flipped = 1'b1;
      else flipped = ({1'b0, at_row} >= swl);
      if (!flipped) return (mode == MODE_KEEP_A) ? (ci == SHARED_A) : (ci == SHARED_B);
      return (mode == MODE_KEEP_A) ? (ci == SHARED_B) : (ci == SHARED_A);
    endfunction

    function int unsigned first_kept(int unsigned from, logic [LINE_W-1:0] at_row);
      int unsigned c;
      c = from;
      while (c < NCH && !slot_kept(c, at_row)) c++;
      return c;
    endfunction

    function void note_word(logic [WORD_W-1:0] w);
      int unsigned width, ci, nxt;
      demux_sample_t s;
      n_words++;
      if (skip_left != 0) begin
        skip_left--;
        return;
      end
      if (finished || row >= lcnt) return;
      width = (spl == 0) ? 1 : (spl > MAXS) ? MAXS : spl;
      ci = first_kept(slot, row);
      if (ci >= NCH) ci = first_kept(0, row);
      s.chan  = CHO_W'(ci);
      s.row   = row;
      s.pixel = pixel;
      s.word  = w;
      s.done  = 1'b0;
      nxt = first_kept(ci + 1, row);
      if (nxt < NCH) begin
        slot = CHO_W'(nxt);
      end else begin
        slot = '0;
        if (32'(pixel) + 1 >= width) begin
          pixel     = '0;
          skip_left = GAP_WORDS;
          if (32'(row) + 1 >= 32'(lcnt)) begin
            s.done   = 1'b1;
            finished = 1'b1;
          end
          row = row + 1'b1;
        end else begin
          pixel = pixel + 1'b1;
        end
      end
      pending_samples.push_back(s);
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_sample(demux_sample_t got);
      demux_sample_t want;
      if (pending_samples.size() == 0) begin
        report($sformatf("unexpected sample ch %0d line %0d pixel %0d word %0h",
                         got.chan, got.row, got.pixel, got.word));
        return;
      end
      want = pending_samples.pop_front();
      if (got.chan !== want.chan)
        report($sformatf("channel %0d, want %0d", got.chan, want.chan));
      if (got.row !== want.row)
        report($sformatf("line %0d, want %0d", got.row, want.row));
      if (got.pixel !== want.pixel)
        report($sformatf("pixel %0d, want %0d", got.pixel, want.pixel));
      if (got.word !== want.word)
        report($sformatf("sample %0h, want %0h", got.word, want.word));
      if (got.done !== want.done)
        report($sformatf("image done %0b, want %0b", got.done, want.done));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [WORD_W-1:0]   in_sample_word;
  logic                out_valid;
  logic                out_ready;
  logic [CHO_W-1:0]    out_channel_index;
  logic [LINE_W-1:0]   out_line_index;
  logic [PIXO_W-1:0]   out_pixel_index;
  logic [WORD_W-1:0]   out_sample_value;
  logic                out_image_done;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  sample_tracker tracker;
  bit            calm;          // no random idling on either side while set
  int unsigned   hold_asks;     // bumped to ask the result side for a long hold-off
  int unsigned   cycle_count = 0;

  radiometer_channel_demux #(
    .NUM_CHANNELS (NCH),
    .MAX_SAMPLES  (MAXS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_word    (in_sample_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_line_index    (out_line_index),
    .out_pixel_index   (out_pixel_index),
    .out_sample_value  (out_sample_value),
    .out_image_done    (out_image_done),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: sampled on the falling edge ahead of the edge that takes the request,
  // when ready and the payload are already settled
  always @(negedge clk) begin : result_monitor
    demux_sample_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.chan  = out_channel_index;
      seen.row   = out_line_index;
      seen.pixel = out_pixel_index;
      seen.word  = out_sample_value;
      seen.done  = out_image_done;
      tracker.check_sample(seen);
    end
  end

  // result side ready: random stalls, plus the long hold-off when asked
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // one register write: setup cycle, access cycle, then a bus idle cycle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    bit taken;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      taken = pready;
      @(posedge clk);
    end while (!taken);
    tracker.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer n_words word requests; with until_done the count starts only once
  // the last line has closed, so words after the end of the image follow
  task automatic run_phase(input int unsigned n_words, input bit hold_off,
                           input bit until_done);
    int unsigned k;
    bit asked, taken;
    logic [WORD_W-1:0] w;
    k = 0;
    asked = 1'b0;
    while (k < n_words) begin
      // ask for the hold-off once samples start flowing, so the block backs up
      if (hold_off && !asked && tracker.pending_samples.size() != 0) begin
        hold_asks++;
        asked = 1'b1;
      end
      case ($urandom_range(0, 15))
        0:       w = '0;
        1:       w = '1;
        default: w = WORD_W'($urandom_range(0, 1023));
      endcase
      while (!calm && $urandom_range(0, 99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid       <= 1'b1;
      in_sample_word <= w;
      do begin
        @(negedge clk);
        taken = in_ready;
        @(posedge clk);
      end while (!taken);
      tracker.note_word(w);
      if (!until_done || tracker.finished) k++;
    end
    in_valid <= 1'b0;
  endtask

  // all owed samples in, then let dropped words clear the pipeline
  task automatic settle();
    while (tracker.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_no, r, lc;
    logic [DATA_W-1:0] v;

    tracker        = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample_word = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    calm           = 1'b0;
    hold_asks      = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---

    // reset settings: the header is skipped, then zero lines means all dropped
    run_phase(60, 1'b0, 1'b0);

    // zero width behaves as one pixel per line; widest line count
    // one short line and its trailing gap
    settle();
    write_reg(REG_SAMPLES_PER_LINE, 0);
    write_reg(REG_LINE_COUNT, 32'h0000_FFFF);
    run_phase(117, 1'b0, 1'b0);

    // the other shared slot modes on one long line, changed part way through it,
    // including both spare codes, which keep both
    settle();
    write_reg(REG_SAMPLES_PER_LINE, 16);
    write_reg(REG_SHARED_SLOT_MODE, MODE_KEEP_B);
    run_phase(20, 1'b0, 1'b0);
    settle();
    write_reg(REG_SHARED_SLOT_MODE, MODE_KEEP_BOTH);
    run_phase(20, 1'b0, 1'b0);
    settle();
    write_reg(REG_SHARED_SLOT_MODE, MODE_BOTH_ALT);
    run_phase(20, 1'b0, 1'b0);

    // negative switch line other than never: every line flipped
    settle();
    write_reg(REG_SHARED_SLOT_MODE, MODE_KEEP_A);
    write_reg(REG_SWITCH_LINE, 32'hFFFF_0000);
    run_phase(20, 1'b0, 1'b0);

    // oversized width saturates, then the widest legal one, same line
    settle();
    write_reg(REG_SAMPLES_PER_LINE, 8191);
    run_phase(10, 1'b0, 1'b0);
    settle();
    write_reg(REG_SAMPLES_PER_LINE, MAXS);
    run_phase(10, 1'b0, 1'b0);

    // narrowing below the pixel already reached closes the line at once;
    // the switch at the next line shows up after the gap
    settle();
    write_reg(REG_SWITCH_LINE, 32'(tracker.row) + 1);
    write_reg(REG_SAMPLES_PER_LINE, 2);
    run_phase(130, 1'b0, 1'b0);

    // line count dropped under the current line: words go nowhere
    settle();
    write_reg(REG_LINE_COUNT, 0);
    run_phase(20, 1'b0, 1'b0);

    // --- random part ---
    phase_no = 0;
    while (tracker.n_words < RANDOM_WORDS && phase_no < 40) begin
      settle();
      calm = (phase_no >= 2 && phase_no <= 4);

      if (phase_no == 2) begin
        // dense phase: both shared slots, wide line, long result hold-off
        write_reg(REG_SHARED_SLOT_MODE, MODE_KEEP_BOTH);
        write_reg(REG_SAMPLES_PER_LINE, 24);
        write_reg(REG_SWITCH_LINE, SWITCH_NEVER_WORD);
        write_reg(REG_LINE_COUNT, 32'(tracker.row) + 100);
        run_phase(160, 1'b1, 1'b0);
      end else begin
        // width: mostly narrow, now and then the extremes
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(0, 19);
          if (r == 0) v = 0;
          else if (r == 1) v = MAXS;
          else if (r == 2) v = 8191;
          else if (r < 7) v = $urandom_range(7, 60);
          else v = $urandom_range(1, 6);
          write_reg(REG_SAMPLES_PER_LINE, v);
        end
        if ($urandom_range(0, 1))
          write_reg(REG_SHARED_SLOT_MODE, $urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) begin
          r = $urandom_range(0, 5);
          if (r == 0) v = SWITCH_NEVER_WORD;
          else if (r == 1) v = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFE);
          else if (r == 2) v = 0;
          else if (r == 3) v = 32'h0000_FFFF;
          else v = 32'(tracker.row) + $urandom_range(0, 3);
          write_reg(REG_SWITCH_LINE, v);
        end
        // line count always rewritten: mostly far ahead of the current line, now and then at or below it
        r = $urandom_range(0, 9);
        if (r == 0) begin
          lc = $urandom_range(0, tracker.row);
        end else if (r == 1) begin
          lc = 32'h0000_FFFF;
        end else begin
          lc = 32'(tracker.row) + 200 + $urandom_range(0, 800);
          if (lc > 32'h0000_FFFF) lc = 32'h0000_FFFF;
        end
        write_reg(REG_LINE_COUNT, lc);
        run_phase($urandom_range(20, 60), 1'b0, 1'b0);
      end
      phase_no++;
    end
    calm = 1'b0;

    // last phase: close the image on the current line, then words past the end
    settle();
    write_reg(REG_SAMPLES_PER_LINE, 3);
    write_reg(REG_SHARED_SLOT_MODE, $urandom_range(0, 3));
    write_reg(REG_LINE_COUNT, 32'(tracker.row) + 1);
    run_phase(20, 1'b0, 1'b1);

    settle();
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rcd_pkg.sv
sv/rcd_regs.sv
sv/rcd_core.sv
sv/radiometer_channel_demux.sv
sv/rcd_checker.sv
bench/tb_radiometer_channel_demux.sv
